### rtl/vt4_pkg.sv
package vt4_pkg;

  // Q16.16 component and derived widths
  localparam int Q_W      = 32;
  localparam int PROD_W   = 2 * Q_W;         // full 32x32 product
  localparam int FRAC_W   = 16;
  localparam int TERM_W   = PROD_W - FRAC_W; // product after floor shift by 16
  localparam int PAIR_W   = TERM_W + 1;      // sum of two terms
  localparam int SUM_W    = TERM_W + 2;      // sum of four terms
  localparam int DIM      = 4;

  // Configuration register file
  localparam int NUM_REGS  = 8;
  localparam int REG_SEL_W = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 64;

  localparam logic [Q_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [Q_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  // Operation codes (bit 1 selects the full transform, code 3 acts as code 2)
  localparam logic [1:0] OP_DIR   = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_HOMOG = 2'd2;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [CFG_W-1:0]         cfg_word_t;

  // mat[r][c]: row r, column c
  typedef q_t mat_t [DIM][DIM];
  typedef q_t vec_t [DIM];

  // Stage payload: terms per column and row
  typedef struct {
    logic  full;
    term_t term [DIM][DIM];
  } prod_pl_t;

  // Identity matrix after reset
  localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
    {32'h0,  Q_ONE}, 64'h0,
    {Q_ONE,  32'h0}, 64'h0,
    64'h0,           {32'h0, Q_ONE},
    64'h0,           {Q_ONE, 32'h0}
  };

  // Clamp a four-term sum to signed 32 bits
  function automatic q_t sat_q(input sum_t s);
    logic [SUM_W-Q_W:0] hi;
    hi = s[SUM_W-1:Q_W-1];
    if (&hi || ~|hi) begin
      return s[Q_W-1:0];
    end else if (s[SUM_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

### rtl/vt4_in_if.sv
interface vt4_in_if;
  import vt4_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] op;
  q_t         in_x;
  q_t         in_y;
  q_t         in_z;
  q_t         in_w;

  modport source (output valid, op, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, op, in_x, in_y, in_z, in_w, output ready);
endinterface

### rtl/vt4_out_if.sv
interface vt4_out_if;
  import vt4_pkg::*;

  logic valid;
  logic ready;
  q_t   out_x;
  q_t   out_y;
  q_t   out_z;
  q_t   out_w;

  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

### rtl/vt4_cfg_if.sv
interface vt4_cfg_if;
  import vt4_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  cfg_word_t            data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/vertex_transform_4x4_core.sv
// Vertex transform, out = v * M, all values signed Q16.16.
//
// Channels:
//   in_ch  - vertex requests: op plus in_x..in_w. op 0 transforms a direction
//            (rows 0..2), op 1 a 3D point (row 3 added as is), op 2 or 3 the
//            full homogeneous transform (row 3 scaled by in_w).
//   out_ch - one result per vertex, out_x..out_w, each sum saturated to
//            32 bits; out_w is zero for ops 0 and 1.
//   cfg_ch - matrix writes, index 0..7 picks rowN_xy / rowN_zw, larger
//            indexes are ignored. Always ready; write only while idle.
// Timing: four register stages (input, products, pair sums, final sum and
//   saturation); a vertex moves through them in that order. One vertex per
//   cycle is sustained while out_ch.ready stays high; sixteen 32x32
//   multipliers work in parallel in the product stage.
// Reset: pipeline empties and the matrix returns to identity.
// Stall: when out_ch.ready is low, full stages hold from the output back and
//   bubbles are squeezed out; in_ch.ready drops once every stage holds a vertex.
module vertex_transform_4x4_core (
  input  logic      clk,
  input  logic      rst_n,
  vt4_in_if.sink    in_ch,
  vt4_out_if.source out_ch,
  vt4_cfg_if.sink   cfg_ch
);
  import vt4_pkg::*;

  mat_t     mat;
  vec_t     in_vec;
  vec_t     out_vec;
  logic     prod_valid;
  logic     prod_ready;
  prod_pl_t prod_pl;

  assign cfg_ch.ready = 1'b1;

  vt4_coef_regs u_coef_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .mat      (mat)
  );

  assign in_vec[0] = in_ch.in_x;
  assign in_vec[1] = in_ch.in_y;
  assign in_vec[2] = in_ch.in_z;
  assign in_vec[3] = in_ch.in_w;

  vt4_mult_stage u_mult_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .mat      (mat),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_op    (in_ch.op),
    .up_vec   (in_vec),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_pl    (prod_pl)
  );

  vt4_accum_stage u_accum_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_pl    (prod_pl),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_vec   (out_vec)
  );

  assign out_ch.out_x = out_vec[0];
  assign out_ch.out_y = out_vec[1];
  assign out_ch.out_z = out_vec[2];
  assign out_ch.out_w = out_vec[3];

endmodule

### rtl/vt4_coef_regs.sv
module vt4_coef_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_valid,
  input  logic [vt4_pkg::CFG_IDX_W-1:0] wr_index,
  input  vt4_pkg::cfg_word_t            wr_data,
  output vt4_pkg::mat_t                 mat
);
  import vt4_pkg::*;

  cfg_word_t regs_r [NUM_REGS];
  logic      wr_hit;

  // Indexes past the register file are dropped
  assign wr_hit = wr_valid && (wr_index < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= CFG_RESET[i];
      end
    end else if (wr_hit) begin
      regs_r[wr_index[REG_SEL_W-1:0]] <= wr_data;
    end
  end

  // Coefficient M[r][c] sits in register 2r + c/2, odd columns in the high half
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        if (c % 2 == 1) begin
          mat[r][c] = regs_r[2*r + c/2][CFG_W-1:Q_W];
        end else begin
          mat[r][c] = regs_r[2*r + c/2][Q_W-1:0];
        end
      end
    end
  end

endmodule

### rtl/vt4_mult_stage.sv
module vt4_mult_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  vt4_pkg::mat_t       mat,
  // vertex request
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [1:0]          up_op,
  input  vt4_pkg::vec_t       up_vec,
  // product terms
  output logic                dn_valid,
  input  logic                dn_ready,
  output vt4_pkg::prod_pl_t   dn_pl
);
  import vt4_pkg::*;

  logic       s1_vld_r;
  logic [1:0] s1_op_r;
  vec_t       s1_vec_r;
  logic       s2_vld_r;
  prod_pl_t   s2_pl_r;
  prod_pl_t   s2_pl_nxt;
  logic       s1_en;
  logic       s2_en;
  logic       full;
  logic       point;

  // Stage advances when empty or when its successor advances
  assign s2_en    = !s2_vld_r || dn_ready;
  assign s1_en    = !s1_vld_r || s2_en;
  assign up_ready = s1_en;

  // Stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && up_valid) begin
      s1_op_r  <= up_op;
      s1_vec_r <= up_vec;
    end
  end

  // Mode decode
  assign full  = s1_op_r[1];
  assign point = s1_op_r[1] || (s1_op_r == OP_POINT);

  // Sixteen products, floor-shifted to Q32.16; row 3 depends on the mode
  always_comb begin
    logic signed [PROD_W-1:0] prod;
    s2_pl_nxt.full = full;
    for (int c = 0; c < DIM; c++) begin
      for (int r = 0; r < DIM; r++) begin
        prod = $signed(s1_vec_r[r]) * $signed(mat[r][c]);
        if (r < DIM - 1 || full) begin
          s2_pl_nxt.term[c][r] = prod[PROD_W-1:FRAC_W];
        end else if (point) begin
          s2_pl_nxt.term[c][r] = TERM_W'($signed(mat[r][c]));
        end else begin
          s2_pl_nxt.term[c][r] = '0;
        end
      end
    end
  end

  // Stage 2: product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_vld_r) begin
      s2_pl_r <= s2_pl_nxt;
    end
  end

  assign dn_valid = s2_vld_r;
  assign dn_pl    = s2_pl_r;

endmodule

### rtl/vt4_accum_stage.sv
module vt4_accum_stage (
  input  logic              clk,
  input  logic              rst_n,
  // product terms
  input  logic              up_valid,
  output logic              up_ready,
  input  vt4_pkg::prod_pl_t up_pl,
  // result request
  output logic              dn_valid,
  input  logic              dn_ready,
  output vt4_pkg::vec_t     dn_vec
);
  import vt4_pkg::*;

  logic  s3_vld_r;
  logic  s3_full_r;
  pair_t s3_pair_r [DIM][2];
  pair_t s3_pair_nxt [DIM][2];
  logic  s4_vld_r;
  vec_t  s4_vec_r;
  vec_t  s4_vec_nxt;
  logic  s3_en;
  logic  s4_en;

  assign s4_en    = !s4_vld_r || dn_ready;
  assign s3_en    = !s3_vld_r || s4_en;
  assign up_ready = s3_en;

  // Pairwise sums per column
  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      s3_pair_nxt[c][0] = PAIR_W'($signed(up_pl.term[c][0]))
                        + PAIR_W'($signed(up_pl.term[c][1]));
      s3_pair_nxt[c][1] = PAIR_W'($signed(up_pl.term[c][2]))
                        + PAIR_W'($signed(up_pl.term[c][3]));
    end
  end

  // Stage 3: pair-sum register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_en) begin
      s3_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && up_valid) begin
      s3_full_r <= up_pl.full;
      s3_pair_r <= s3_pair_nxt;
    end
  end

  // Final sum and saturation; w is zero unless the full transform ran
  always_comb begin
    sum_t sum;
    for (int c = 0; c < DIM; c++) begin
      sum = SUM_W'($signed(s3_pair_r[c][0])) + SUM_W'($signed(s3_pair_r[c][1]));
      s4_vec_nxt[c] = sat_q(sum);
    end
    if (!s3_full_r) begin
      s4_vec_nxt[DIM-1] = '0;
    end
  end

  // Stage 4: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (s4_en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en && s3_vld_r) begin
      s4_vec_r <= s4_vec_nxt;
    end
  end

  assign dn_valid = s4_vld_r;
  assign dn_vec   = s4_vec_r;

endmodule

### verif/vertex_transform_4x4_core_tb.sv
`timescale 1ns / 100ps

module vertex_transform_4x4_core_tb;
  import vt4_pkg::*;

  localparam int     PIPE_DEPTH  = 4;
  localparam int     CYCLE_LIMIT = 400_000;
  localparam int     MAX_REPORTS = 40;
  localparam int     RELOAD_EVERY = 104;
  localparam longint SAT_HI = (longint'(1) <<< 31) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< 31);

  // op 3 decodes like the homogeneous transform
  localparam logic [1:0] OP_HOMOG_ALIAS = 2'd3;

  // register indexes that fall outside the matrix
  localparam logic [CFG_IDX_W-1:0] IDX_PAST_END = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] IDX_TOP      = {CFG_IDX_W{1'b1}};

  typedef enum int {
    ROW0_XY, ROW0_ZW, ROW1_XY, ROW1_ZW, ROW2_XY, ROW2_ZW, ROW3_XY, ROW3_ZW
  } mat_reg_e;

  typedef enum int { MAT_SMALL, MAT_FULL, MAT_MIXED } mat_kind_e;

  typedef struct packed {
    logic [1:0] op;
    q_t         x;
    q_t         y;
    q_t         z;
    q_t         w;
  } vertex_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
    q_t w;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  vt4_in_if  in_ch ();
  vt4_out_if out_ch ();
  vt4_cfg_if cfg_ch ();

  vertex_transform_4x4_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the matrix registers
  cfg_word_t mat_shadow [NUM_REGS] = CFG_RESET;

  result_t pending_results [$];
  result_t got_res;
  result_t want_res;
  int      src_idle_pct = 20;
  int      snk_idle_pct = 69;
  int      mismatch_count = 0;
  int      vertices_sent = 0;
  int      results_checked = 0;
  int      matrix_loads = 0;
  int      cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // ---------------- prediction ----------------

  function automatic q_t mat_coeff(input int row, input int col);
    cfg_word_t wd;
    wd = mat_shadow[2 * row + col / 2];
    return (col % 2) ? wd[Q_W +: Q_W] : wd[0 +: Q_W];
  endfunction

  // full-precision product, floored back to Q16.16
  function automatic longint scaled_term(input q_t a, input q_t b);
    return (longint'(a) * longint'(b)) >>> FRAC_W;
  endfunction

  function automatic q_t clamp_q(input longint s);
    if (s > SAT_HI) return Q_MAX;
    if (s < SAT_LO) return Q_MIN;
    return s[Q_W-1:0];
  endfunction

  function automatic result_t transform_vertex(input vertex_t v);
    q_t      comp [DIM];
    q_t      col_out [DIM];
    longint  acc;
    logic    homog;
    logic    point;
    result_t r;
    comp  = '{v.x, v.y, v.z, v.w};
    homog = v.op[1];  // ops 2 and 3
    point = (v.op == OP_POINT);
    for (int c = 0; c < DIM; c++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        acc += scaled_term(comp[k], mat_coeff(k, c));
      end
      if (homog) begin
        acc += scaled_term(comp[3], mat_coeff(3, c));
      end else if (point) begin
        acc += longint'(mat_coeff(3, c));  // translation added as is
      end
      col_out[c] = clamp_q(acc);
    end
    if (!homog) col_out[3] = '0;
    r.x = col_out[0];
    r.y = col_out[1];
    r.z = col_out[2];
    r.w = col_out[3];
    return r;
  endfunction

  // ---------------- result checking ----------------

  task automatic check_field(input string name, input q_t got, input q_t want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h (result %0d)", name, got, want,
                                results_checked));
    end
  endtask

  // results are checked before this edge's request is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got_res = '{out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_w};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got_res));
        end else begin
          want_res = pending_results.pop_front();
          check_field("out_x", got_res.x, want_res.x);
          check_field("out_y", got_res.y, want_res.y);
          check_field("out_z", got_res.z, want_res.z);
          check_field("out_w", got_res.w, want_res.w);
        end
        results_checked++;
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(transform_vertex('{in_ch.op, in_ch.in_x, in_ch.in_y,
                                                     in_ch.in_z, in_ch.in_w}));
        vertices_sent++;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // ---------------- drivers ----------------

  // all driver tasks start and end on a falling edge
  task automatic send_vertex(input vertex_t v);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= v.op;
    in_ch.in_x  <= v.x;
    in_ch.in_y  <= v.y;
    in_ch.in_z  <= v.z;
    in_ch.in_w  <= v.w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the sender until every pending result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_matrix_word(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx < NUM_REGS) mat_shadow[idx[REG_SEL_W-1:0]] = data;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_matrix(input cfg_word_t words [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      write_matrix_word(CFG_IDX_W'(i), words[i]);
    end
    matrix_loads++;
  endtask

  task automatic load_uniform(input q_t coeff);
    cfg_word_t words [NUM_REGS];
    foreach (words[i]) words[i] = {coeff, coeff};
    load_matrix(words);
  endtask

  // ---------------- random values ----------------

  function automatic q_t small_q();
    logic [19:0] r;
    r = 20'($urandom);
    return {{(Q_W-20){r[19]}}, r};  // within +-8.0
  endfunction

  function automatic q_t rand_q();
    case ($urandom_range(9))
      0, 1, 2, 3: return small_q();
      4, 5, 6:    return $urandom;
      7:          return Q_MAX;
      8:          return Q_MIN;
      default: begin
        case ($urandom_range(2))
          0:       return '0;
          1:       return Q_ONE;
          default: return q_t'(0) - q_t'(Q_ONE);
        endcase
      end
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.op = 2'($urandom_range(3));
    v.x  = rand_q();
    v.y  = rand_q();
    v.z  = rand_q();
    v.w  = rand_q();
    return v;
  endfunction

  task automatic load_random_matrix(input mat_kind_e kind);
    cfg_word_t words [NUM_REGS];
    foreach (words[i]) begin
      case (kind)
        MAT_SMALL: words[i] = {small_q(), small_q()};
        MAT_FULL:  words[i] = {$urandom, $urandom};
        default:   words[i] = {rand_q(), rand_q()};
      endcase
    end
    load_matrix(words);
  endtask

  // ---------------- tests ----------------

  // identity from reset, every op, then a translation row
  task automatic test_identity_ops();
    vertex_t v;
    v = '{OP_DIR, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0005_0000};
    send_vertex(v);
    v.op = OP_POINT;       send_vertex(v);
    v.op = OP_HOMOG;       send_vertex(v);
    v.op = OP_HOMOG_ALIAS; send_vertex(v);
    drain_results();
    write_matrix_word(CFG_IDX_W'(ROW3_XY), {32'hfffe_0000, 32'h0003_8000});
    write_matrix_word(CFG_IDX_W'(ROW3_ZW), {Q_ONE, 32'h0000_4000});
    v.op = OP_DIR;   send_vertex(v);
    v.op = OP_POINT; send_vertex(v);
    v.op = OP_HOMOG; send_vertex(v);
    drain_results();
  endtask

  // writes past the last register must leave the matrix alone
  task automatic test_ignored_index();
    write_matrix_word(IDX_PAST_END, {$urandom, $urandom});
    write_matrix_word(IDX_TOP, {$urandom, $urandom});
    send_vertex('{OP_HOMOG, 32'h0001_8000, 32'hffff_0000, 32'h0000_0001, Q_ONE});
    drain_results();
  endtask

  // floor rounding of negative products and saturation at both ends
  task automatic test_extremes();
    load_uniform(32'h0000_0001);
    send_vertex('{OP_HOMOG, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff});
    send_vertex('{OP_DIR, 32'hffff_8000, 32'h0000_7fff, 32'h0000_0000, 32'h0000_0000});
    drain_results();
    load_uniform(Q_MAX);
    send_vertex('{OP_HOMOG, Q_MAX, Q_MAX, Q_MAX, Q_MAX});
    send_vertex('{OP_HOMOG, Q_MIN, Q_MIN, Q_MIN, Q_MIN});
    send_vertex('{OP_POINT, Q_MAX, Q_MIN, Q_MAX, Q_MIN});
    send_vertex('{OP_POINT, 32'h0, 32'h0, 32'h0, Q_MAX});
    drain_results();
    load_uniform(Q_MIN);
    send_vertex('{OP_HOMOG_ALIAS, Q_MIN, Q_MIN, Q_MIN, Q_MIN});
    send_vertex('{OP_DIR, 32'h0, 32'h0, 32'h0, Q_MIN});
    send_vertex('{OP_POINT, 32'h0, 32'h0, 32'h0, Q_MAX});
    send_vertex('{OP_HOMOG, Q_MAX, Q_MAX, Q_MAX, Q_MAX});
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % RELOAD_EVERY == 0) begin
        drain_results();
        load_random_matrix(mat_kind_e'(matrix_loads % 3));
      end
      send_vertex(rand_vertex());
    end
    drain_results();
  endtask

  // ---------------- sequence ----------------

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_DIR;
    in_ch.in_x   = '0;
    in_ch.in_y   = '0;
    in_ch.in_z   = '0;
    in_ch.in_w   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_identity_ops();
    test_ignored_index();
    test_extremes();
    test_random_traffic(416, 20, 69);
    test_random_traffic(416, 69, 20);
    test_random_traffic(416, 0, 0);

    in_ch.valid <= 1'b0;
    drain_results();
    repeat (4 * PIPE_DEPTH) @(posedge clk);

    $display("Covered %0d vertices over ops 0-3, floor rounding, saturation and %0d matrices",
             vertices_sent, matrix_loads);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/vt4_pkg.sv
rtl/vt4_in_if.sv
rtl/vt4_out_if.sv
rtl/vt4_cfg_if.sv
rtl/vt4_coef_regs.sv
rtl/vt4_mult_stage.sv
rtl/vt4_accum_stage.sv
rtl/vertex_transform_4x4_core.sv
verif/vertex_transform_4x4_core_tb.sv
